/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside of reset.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Property checked on every rising clock edge, reset included.
`define ASSERT_CLK(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

/* rtl/core/ib2c_pkg.sv */
// Constants and types for the bitplane to chunky pixel converter.
package ib2c_pkg;

  localparam int MaxRowBytes = 64;
  localparam int MaxPlanes   = 8;
  localparam int StorePlanes = MaxPlanes - 1;
  localparam int MaxWidth    = MaxRowBytes * 8;

  localparam int ColW   = (MaxRowBytes > 1) ? $clog2(MaxRowBytes) : 1;
  localparam int BytesW = ColW + 1;
  localparam int PlW    = (MaxPlanes > 1) ? $clog2(MaxPlanes) : 1;
  localparam int WidthW = $clog2(MaxWidth + 1);

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 10;

  localparam logic [CfgIdxW-1:0] CfgImageWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgImageHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPlaneCount  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgColorOffset = 2'd3;

  localparam logic [9:0] WidthReset  = 10'd16;
  localparam logic [9:0] HeightReset = 10'd32;
  localparam logic [3:0] PlanesReset = 4'd5;
  localparam logic [7:0] OffsetReset = 8'd0;

  // One column of stored plane bytes, lane p holds plane p.
  typedef logic [StorePlanes-1:0][7:0] col_word_t;

endpackage

/* rtl/core/interleaved_bitplane_to_chunky.sv */
// Interleaved bitplane to chunky pixel converter, top level.
// A last-plane byte passes the job register, the pixel shifter and the output register.
// Throughput: earlier-plane bytes are taken one per cycle while in_stall_o is low; a last-plane
// byte yields one pixel per cycle while out_stall_i is low, so the 64 x 56 bit column store and
// the pixel shifter hold the input until the shifter is free for the next column.
// Reset clears position, handshakes and config registers to defaults; the store is not cleared.
module interleaved_bitplane_to_chunky (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ib2c_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ib2c_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    plane_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    pixel_color_o,
  output logic                          group_last_o,
  output logic                          row_last_o,
  output logic                          image_last_o
);

  // Configuration registers.
  logic [9:0] width_q, height_q;
  logic [3:0] planes_q;
  logic [7:0] offset_q;

  // Position in the image.
  logic [ib2c_pkg::ColW-1:0] col_q;
  logic [ib2c_pkg::PlW-1:0]  pl_q;
  logic [9:0]                row_q;

  // Effective geometry.
  logic [ib2c_pkg::WidthW-1:0] w_eff;
  logic [ib2c_pkg::WidthW-1:0] w_round;
  logic [ib2c_pkg::BytesW-1:0] bytes;
  logic [9:0]                  h_eff;
  logic [3:0]                  np_eff;
  logic [ib2c_pkg::PlW-1:0]    np_m1;

  always_comb begin
    if (width_q == 10'd0) begin
      w_eff = ib2c_pkg::WidthW'(1);
    end else if (32'(width_q) > ib2c_pkg::MaxWidth) begin
      w_eff = ib2c_pkg::WidthW'(ib2c_pkg::MaxWidth);
    end else begin
      w_eff = ib2c_pkg::WidthW'(width_q);
    end
    // The rounded width stays below 1024, so bits 9 to 3 give the byte count.
    w_round = w_eff + ib2c_pkg::WidthW'(7);
    bytes   = w_round[ib2c_pkg::WidthW-1 -: ib2c_pkg::BytesW];
    h_eff   = (height_q == 10'd0) ? 10'd1 : height_q;
    if (planes_q == 4'd0) begin
      np_eff = 4'd1;
    end else if (32'(planes_q) > ib2c_pkg::MaxPlanes) begin
      np_eff = 4'(ib2c_pkg::MaxPlanes);
    end else begin
      np_eff = planes_q;
    end
    np_m1 = ib2c_pkg::PlW'(np_eff - 4'd1);
  end

  // Input stage decode.
  logic                        in_acc;
  logic                        last_plane;
  logic [ib2c_pkg::BytesW-1:0] col_inc;
  logic                        row_end;
  logic                        img_end;
  logic [3:0]                  grp_n;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign last_plane = (pl_q == np_m1);
  assign col_inc    = {1'b0, col_q} + ib2c_pkg::BytesW'(1);
  assign row_end    = (col_inc == bytes);
  assign img_end    = row_end && ({1'b0, row_q} + 11'd1 >= {1'b0, h_eff});
  assign grp_n      = (row_end && (w_eff[2:0] != 3'd0)) ? {1'b0, w_eff[2:0]} : 4'd8;

  // Column store: one word per byte column, one byte lane per earlier plane.
  ib2c_pkg::col_word_t mem_q [ib2c_pkg::MaxRowBytes];
  ib2c_pkg::col_word_t rd_q;

  always_ff @(posedge clk_i) begin
    if (in_acc && !last_plane) begin
      mem_q[col_q][pl_q] <= plane_byte_i;
    end
    if (in_acc && last_plane) begin
      rd_q <= mem_q[col_q];
    end
  end

  // Pending column job, waiting for its store read and for the shifter.
  logic       job_valid_q;
  logic [7:0] job_data_q;
  logic [3:0] job_n_q;
  logic       job_row_end_q, job_img_end_q;

  // Pixel shifter.
  logic                grp_valid_q;
  ib2c_pkg::col_word_t grp_planes_q;
  logic [7:0]          grp_data_q;
  logic [2:0]          grp_k_q;
  logic [3:0]          grp_n_q;
  logic                grp_row_end_q, grp_img_end_q;

  logic out_valid_q;
  logic out_load, grp_last, grp_load;

  assign out_load   = grp_valid_q && (!out_valid_q || !out_stall_i);
  assign grp_last   = ({1'b0, grp_k_q} == grp_n_q - 4'd1);
  assign grp_load   = job_valid_q && (!grp_valid_q || (out_load && grp_last));
  assign in_stall_o = job_valid_q && !grp_load;

  // Stack the plane bits of the current pixel.
  logic [7:0] color;
  logic [2:0] bit_sel;

  always_comb begin
    bit_sel = 3'd7 - grp_k_q;
    color   = '0;
    for (int p = 0; p < ib2c_pkg::MaxPlanes; p++) begin
      if (ib2c_pkg::PlW'(p) == np_m1) begin
        color[p] = grp_data_q[bit_sel];
      end
    end
    for (int p = 0; p < ib2c_pkg::StorePlanes; p++) begin
      if (ib2c_pkg::PlW'(p) < np_m1) begin
        color[p] = grp_planes_q[p][bit_sel];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= ib2c_pkg::WidthReset;
      height_q    <= ib2c_pkg::HeightReset;
      planes_q    <= ib2c_pkg::PlanesReset;
      offset_q    <= ib2c_pkg::OffsetReset;
      col_q       <= '0;
      pl_q        <= '0;
      row_q       <= '0;
      job_valid_q <= 1'b0;
      grp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          ib2c_pkg::CfgImageWidth:  width_q  <= cfg_data_i;
          ib2c_pkg::CfgImageHeight: height_q <= cfg_data_i;
          ib2c_pkg::CfgPlaneCount:  planes_q <= cfg_data_i[3:0];
          ib2c_pkg::CfgColorOffset: offset_q <= cfg_data_i[7:0];
          default: ;
        endcase
        col_q <= '0;
        pl_q  <= '0;
        row_q <= '0;
      end else if (in_acc) begin
        if (row_end) begin
          col_q <= '0;
          if (last_plane) begin
            pl_q  <= '0;
            row_q <= img_end ? 10'd0 : row_q + 10'd1;
          end else begin
            pl_q <= pl_q + ib2c_pkg::PlW'(1);
          end
        end else begin
          col_q <= col_inc[ib2c_pkg::ColW-1:0];
        end
      end

      if (in_acc && last_plane) begin
        job_valid_q <= 1'b1;
      end else if (grp_load) begin
        job_valid_q <= 1'b0;
      end

      if (grp_load) begin
        grp_valid_q <= 1'b1;
      end else if (out_load && grp_last) begin
        grp_valid_q <= 1'b0;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc && last_plane) begin
      job_data_q    <= plane_byte_i;
      job_n_q       <= grp_n;
      job_row_end_q <= row_end;
      job_img_end_q <= img_end;
    end
    if (grp_load) begin
      grp_planes_q  <= rd_q;
      grp_data_q    <= job_data_q;
      grp_n_q       <= job_n_q;
      grp_row_end_q <= job_row_end_q;
      grp_img_end_q <= job_img_end_q;
      grp_k_q       <= '0;
    end else if (out_load) begin
      grp_k_q <= grp_k_q + 3'd1;
    end
    if (out_load) begin
      pixel_color_o <= color + offset_q;
      group_last_o  <= grp_last;
      row_last_o    <= grp_last && grp_row_end_q;
      image_last_o  <= grp_last && grp_img_end_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/core/ib2c_checker.sv */
// Port-level checker for the bitplane to chunky converter, with its bind.
`include "assert_macros.svh"

module ib2c_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic group_last_o,
  input logic row_last_o,
  input logic image_last_o
);

  // A stalled result transaction keeps its valid.
  `ASSERT_CLK_RST(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o)

  // The last pixel of an image ends its row, and a row ends on a group boundary.
  `ASSERT_CLK_RST(a_image_ends_row, clk_i, rst_ni, out_valid_o && image_last_o |-> row_last_o)
  `ASSERT_CLK_RST(a_row_ends_group, clk_i, rst_ni, out_valid_o && row_last_o |-> group_last_o)

  // Pixels of one group leave without gaps.
  `ASSERT_CLK_RST(a_group_gapless, clk_i, rst_ni, out_valid_o && !out_stall_i && !group_last_o |=> out_valid_o)

  // No result is offered while reset is held.
  `ASSERT_CLK(a_reset_quiet, clk_i, !rst_ni |=> !out_valid_o)

endmodule

bind interleaved_bitplane_to_chunky ib2c_checker u_ib2c_checker (.*);
